// ===== hdl/pscbr_pkg.sv =====
// Shared constants, codes and types for the ping-pong serial capture bus reader.
package pscbr_pkg;

    localparam int BUFFER_BYTES_DEF = 64;
    localparam int BYTE_W           = 8;
    localparam int COUNT_W          = 7;
    localparam int OP_W             = 3;
    localparam int CFG_INDEX_W      = 1;

    localparam logic [BYTE_W-1:0] HDR_OVERFLOW   = 8'h80;
    localparam logic [BYTE_W-1:0] LED_LONG_MS    = 8'd200;
    localparam logic [BYTE_W-1:0] LED_SHORT_MS   = 8'd2;
    localparam logic [BYTE_W-1:0] START_CODE_RST = 8'd1;
    localparam logic [BYTE_W-1:0] STOP_CODE_RST  = 8'd2;

    typedef enum logic [OP_W-1:0] {
        OP_SERIAL  = 3'd0,
        OP_RD_ADDR = 3'd1,
        OP_WR_ADDR = 3'd2,
        OP_CMD     = 3'd3,
        OP_DATA_RD = 3'd4,
        OP_TICK    = 3'd5
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_START_CODE = 1'b0,
        CFG_STOP_CODE  = 1'b1
    } cfg_idx_t;

    // Result of one transaction, handed from the controller to the output stage
    typedef struct packed {
        logic              valid;
        logic              from_mem;
        logic [BYTE_W-1:0] bus;
    } res_t;

endpackage

// ===== hdl/pingpong_serial_capture_bus_reader.sv =====
// Top level: ping-pong serial capture buffer drained over a byte-wide bus.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+-------------------------------
//  command   | start / busy            | operation, data_byte
//  result    | done (one-cycle strobe) | bus_data, led_on
//  config    | cfg_write               | cfg_index, cfg_data
//
// One transaction per cycle while busy is low; the result appears in the cycle after
// acceptance, set by the registered read of the byte store RAM.
// busy is high only in the first cycle after reset.
// Reset clears counts, flags, read index and LED timer; store contents are
// undefined until written. The receiver cannot stall: each result shows once.
module pingpong_serial_capture_bus_reader #(
    parameter int BUFFER_BYTES = pscbr_pkg::BUFFER_BYTES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [pscbr_pkg::OP_W-1:0]         operation,
    input  logic [pscbr_pkg::BYTE_W-1:0]       data_byte,
    output logic                               done,
    output logic [pscbr_pkg::BYTE_W-1:0]       bus_data,
    output logic                               led_on,
    input  logic                               cfg_write,
    input  logic [pscbr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [pscbr_pkg::BYTE_W-1:0]       cfg_data
);

    localparam int DEPTH = 2 * BUFFER_BYTES;
    localparam int AW    = $clog2(DEPTH);

    logic                         accept;
    logic                         busy_reg;
    logic                         done_reg;
    logic                         from_mem_reg;
    logic [pscbr_pkg::BYTE_W-1:0] bus_reg;
    logic                         ram_we;
    logic [AW-1:0]                ram_addr;
    logic [pscbr_pkg::BYTE_W-1:0] ram_rdata;
    pscbr_pkg::res_t              res;

    assign accept = start && !busy_reg;

    pscbr_ctrl #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .operation (operation),
        .data_byte (data_byte),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .res       (res),
        .led_on    (led_on)
    );

    pscbr_ram #(
        .WIDTH (pscbr_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (data_byte),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= 1'b0;
            done_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        from_mem_reg <= res.from_mem;
        bus_reg      <= res.bus;
    end

    // pick the stored byte straight off the RAM read register
    assign bus_data = from_mem_reg ? ram_rdata : bus_reg;
    assign done     = done_reg;
    assign busy     = busy_reg;

    a_done_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("result strobe without an accepted transaction");

    a_mem_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (done && from_mem_reg) |-> $past(operation == pscbr_pkg::OP_DATA_RD))
        else $error("store data returned for a transaction other than a data read");

    a_led_off_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(led_on) |-> $past(start && !busy && operation == pscbr_pkg::OP_TICK))
        else $error("LED turned off without a millisecond tick");

endmodule

// ===== hdl/pscbr_ram.sv =====
// Generic single-port synchronous RAM with registered read.
module pscbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/pscbr_ctrl.sv =====
// Controller: buffer counts, flags, read index, LED timer and RAM access decode.
module pscbr_ctrl #(
    parameter int BUFFER_BYTES = pscbr_pkg::BUFFER_BYTES_DEF,
    localparam int AW          = $clog2(2 * BUFFER_BYTES)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  logic [pscbr_pkg::OP_W-1:0]         operation,
    input  logic [pscbr_pkg::BYTE_W-1:0]       data_byte,
    input  logic                               cfg_write,
    input  logic [pscbr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [pscbr_pkg::BYTE_W-1:0]       cfg_data,
    output logic                               ram_we,
    output logic [AW-1:0]                      ram_addr,
    output pscbr_pkg::res_t                    res,
    output logic                               led_on
);

    localparam logic [pscbr_pkg::COUNT_W-1:0] FILL_MAX = pscbr_pkg::COUNT_W'(BUFFER_BYTES - 1);
    localparam logic [AW-1:0]                 HALF     = AW'(BUFFER_BYTES);

    logic [pscbr_pkg::BYTE_W-1:0]  start_code_reg, stop_code_reg;
    logic [pscbr_pkg::COUNT_W-1:0] cnt0_reg, cnt0_next, cnt1_reg, cnt1_next;
    logic [1:0]                    ovf_reg, ovf_next;
    logic                          fill_sel_reg, fill_sel_next;
    logic [pscbr_pkg::COUNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic                          rx_en_reg, rx_en_next;
    logic [pscbr_pkg::BYTE_W-1:0]  led_cnt_reg, led_cnt_next;
    logic                          led_reg, led_next;

    logic                          dsel;
    logic [pscbr_pkg::COUNT_W-1:0] cnt_fill, cnt_drain;
    logic [AW-1:0]                 fill_addr, drain_addr;
    pscbr_pkg::op_t                op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_code_reg <= pscbr_pkg::START_CODE_RST;
            stop_code_reg  <= pscbr_pkg::STOP_CODE_RST;
        end
        else if (cfg_write)
        begin
            unique case (pscbr_pkg::cfg_idx_t'(cfg_index))
                pscbr_pkg::CFG_START_CODE: start_code_reg <= cfg_data;
                pscbr_pkg::CFG_STOP_CODE:  stop_code_reg  <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt0_reg     <= '0;
            cnt1_reg     <= '0;
            ovf_reg      <= '0;
            fill_sel_reg <= 1'b0;
            rd_idx_reg   <= '0;
            rx_en_reg    <= 1'b0;
            led_cnt_reg  <= '0;
            led_reg      <= 1'b0;
        end
        else
        begin
            cnt0_reg     <= cnt0_next;
            cnt1_reg     <= cnt1_next;
            ovf_reg      <= ovf_next;
            fill_sel_reg <= fill_sel_next;
            rd_idx_reg   <= rd_idx_next;
            rx_en_reg    <= rx_en_next;
            led_cnt_reg  <= led_cnt_next;
            led_reg      <= led_next;
        end
    end

    always_comb
    begin
        op         = pscbr_pkg::op_t'(operation);
        dsel       = ~fill_sel_reg;
        cnt_fill   = fill_sel_reg ? cnt1_reg : cnt0_reg;
        cnt_drain  = fill_sel_reg ? cnt0_reg : cnt1_reg;
        fill_addr  = (fill_sel_reg ? HALF : '0) + AW'(cnt_fill);
        drain_addr = (dsel ? HALF : '0) + AW'(rd_idx_reg);

        cnt0_next     = cnt0_reg;
        cnt1_next     = cnt1_reg;
        ovf_next      = ovf_reg;
        fill_sel_next = fill_sel_reg;
        rd_idx_next   = rd_idx_reg;
        rx_en_next    = rx_en_reg;
        led_cnt_next  = led_cnt_reg;
        led_next      = led_reg;

        ram_we       = 1'b0;
        ram_addr     = (op == pscbr_pkg::OP_SERIAL) ? fill_addr : drain_addr;
        res.valid    = accept;
        res.from_mem = 1'b0;
        res.bus      = '0;

        if (accept)
        begin
            unique case (op)
                pscbr_pkg::OP_SERIAL:
                begin
                    if (rx_en_reg)
                    begin
                        led_next = 1'b1;
                        if (cnt_fill < FILL_MAX)
                        begin
                            ram_we = 1'b1;
                            if (fill_sel_reg)
                            begin
                                cnt1_next = cnt_fill + 1'b1;
                            end
                            else
                            begin
                                cnt0_next = cnt_fill + 1'b1;
                            end
                            if (led_cnt_reg < pscbr_pkg::LED_SHORT_MS)
                            begin
                                led_cnt_next = pscbr_pkg::LED_SHORT_MS;
                            end
                        end
                        else
                        begin
                            // buffer full: drop the byte, flag it
                            ovf_next[fill_sel_reg] = 1'b1;
                            led_cnt_next           = pscbr_pkg::LED_LONG_MS;
                        end
                    end
                end
                pscbr_pkg::OP_RD_ADDR:
                begin
                    // swap roles, empty the new fill buffer, answer with header
                    fill_sel_next = dsel;
                    rd_idx_next   = '0;
                    if (dsel)
                    begin
                        cnt1_next = '0;
                    end
                    else
                    begin
                        cnt0_next = '0;
                    end
                    ovf_next[dsel] = 1'b0;
                    res.bus = {ovf_reg[fill_sel_reg], cnt_fill};
                end
                pscbr_pkg::OP_CMD:
                begin
                    if (data_byte == start_code_reg)
                    begin
                        cnt0_next    = '0;
                        cnt1_next    = '0;
                        rd_idx_next  = '0;
                        rx_en_next   = 1'b1;
                        led_next     = 1'b1;
                        led_cnt_next = pscbr_pkg::LED_LONG_MS;
                    end
                    else if (data_byte == stop_code_reg)
                    begin
                        rx_en_next = 1'b0;
                    end
                end
                pscbr_pkg::OP_DATA_RD:
                begin
                    if (rd_idx_reg < cnt_drain)
                    begin
                        res.from_mem = 1'b1;
                        rd_idx_next  = rd_idx_reg + 1'b1;
                    end
                end
                pscbr_pkg::OP_TICK:
                begin
                    if (led_cnt_reg != '0)
                    begin
                        led_cnt_next = led_cnt_reg - 1'b1;
                        if (led_cnt_reg == 8'd1)
                        begin
                            led_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign led_on = led_reg;

endmodule
